// ===== rtl/bhc_pkg.sv =====
// ----------------------------------------------------------------------------
// bhc_pkg
// Shared widths, types and the CORDIC arctangent table (degrees, 32
// fraction bits) for the bearing and heading correction block.
// ----------------------------------------------------------------------------
`default_nettype none

package bhc_pkg;

   localparam int COORD_WIDTH   = 16;
   localparam int CORDIC_STAGES = 28;
   localparam int ANGLE_FRAC    = 32;
   localparam int GUARD_BITS    = 60 - COORD_WIDTH;
   localparam int XY_W          = 64;
   localparam int ANGLE_W       = ANGLE_FRAC + 8;   // sign + 7 integer bits
   localparam int RAW_W         = ANGLE_FRAC + 9;   // 0..360 with fraction
   localparam int DEG_W         = 9;
   localparam int STAGE_IDX_W   = $clog2(CORDIC_STAGES);
   localparam int REQ_BITS      = 4 * COORD_WIDTH + DEG_W;
   localparam int REQ_W         = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_W         = 24;

   localparam logic [63:0] RAD_TO_DEG_Q32 = 64'd246083499208;

   // Quadrant of (dx, dy), coded as {dx negative, dy negative}
   typedef enum logic [1:0] {
      QUAD_PP = 2'b00,
      QUAD_PN = 2'b01,
      QUAD_NP = 2'b10,
      QUAD_NN = 2'b11
   } quad_type;

   typedef logic signed [ANGLE_W-1:0] angle_type;
   typedef angle_type atan_table_type [CORDIC_STAGES];

   // Side data that rides along the CORDIC chain
   typedef struct packed {
      logic             special;   // exact angle, CORDIC result unused
      logic             sub;       // raw = base - z instead of base + z
      logic [DEG_W-1:0] base;      // whole-degree offset of the raw bearing
      logic [DEG_W-1:0] heading;   // saturated heading
   } side_type;

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      angle_type              z;
      side_type               side;
   } cordic_type;

   // Restoring divide, used only while building the table
   function automatic logic [63:0] udiv64(input logic [63:0] num,
                                          input logic [63:0] den);
      logic [63:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // atan(2^-idx) in degrees: radian series with 62 fraction bits,
   // scaled by 180/pi, low product bits dropped
   function automatic logic [63:0] atan_entry(input int idx);
      logic [63:0]  sum;
      logic [63:0]  term;
      logic [63:0]  num;
      logic [127:0] prod;
      int           k;
      int           n;
      sum = '0;
      k   = 0;
      if (idx == 0) begin
         return 64'd45 << ANGLE_FRAC;
      end
      while (idx * (2 * k + 1) < 62) begin
         n    = idx * (2 * k + 1);
         num  = 64'd1 << (62 - n);
         term = udiv64(num, 64'(2 * k + 1));
         if ((k & 1) != 0) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
         k++;
      end
      prod = {64'd0, sum} * {64'd0, RAD_TO_DEG_Q32};
      return prod[125:62];
   endfunction

   function automatic atan_table_type build_atan_table();
      atan_table_type tbl;
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         tbl[i] = angle_type'(atan_entry(i));
      end
      return tbl;
   endfunction

   localparam atan_table_type ATAN_TABLE = build_atan_table();

endpackage

`default_nettype wire

// ===== rtl/bearing_and_heading_correction.sv =====
// Pipeline: one input stage, the chain of CORDIC cells, two output stages.
// Throughput: one request per cycle while rsp_tready holds; every cell is a
// registered stage with its own ready, so a stalled result only backs up the stages behind it.
// Reset (synchronous, active high) clears all stage valid bits; no state.
// ----------------------------------------------------------------------------
// bearing_and_heading_correction
// Bearing of robot seen from the target (atan2 via a chain of CORDIC
// vectoring cells) and the heading correction wrapped into -180..180.
// ----------------------------------------------------------------------------
`default_nettype none

module bearing_and_heading_correction import bhc_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   // robot_x, robot_y, target_x, target_y, heading_deg, zero fill
   input  wire logic [REQ_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   // bearing_deg, correction_deg, zero fill
   output logic [RSP_W-1:0]      rsp_tdata
);

   cordic_type                 stage_data  [CORDIC_STAGES+1];
   logic                       stage_valid [CORDIC_STAGES+1];
   logic                       stage_ready [CORDIC_STAGES+1];
   logic        [DEG_W-1:0]    bearing_deg;
   logic signed [DEG_W-1:0]    correction_deg;

   // Input stage
   bhc_prep u_prep (
      .clock       (clock),
      .reset       (reset),
      .up_valid    (req_tvalid),
      .up_ready    (req_tready),
      .robot_x     ($signed(req_tdata[0*COORD_WIDTH +: COORD_WIDTH])),
      .robot_y     ($signed(req_tdata[1*COORD_WIDTH +: COORD_WIDTH])),
      .target_x    ($signed(req_tdata[2*COORD_WIDTH +: COORD_WIDTH])),
      .target_y    ($signed(req_tdata[3*COORD_WIDTH +: COORD_WIDTH])),
      .heading_deg (req_tdata[4*COORD_WIDTH +: DEG_W]),
      .dn_valid    (stage_valid[0]),
      .dn_ready    (stage_ready[0]),
      .dn_data     (stage_data[0])
   );

   // Chain of CORDIC cells
   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
      bhc_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift    (STAGE_IDX_W'(g)),
         .atan     (ATAN_TABLE[g]),
         .up_valid (stage_valid[g]),
         .up_ready (stage_ready[g]),
         .up_data  (stage_data[g]),
         .dn_valid (stage_valid[g+1]),
         .dn_ready (stage_ready[g+1]),
         .dn_data  (stage_data[g+1])
      );
   end

   // Output stages
   bhc_post u_post (
      .clock          (clock),
      .reset          (reset),
      .up_valid       (stage_valid[CORDIC_STAGES]),
      .up_ready       (stage_ready[CORDIC_STAGES]),
      .up_data        (stage_data[CORDIC_STAGES]),
      .dn_valid       (rsp_tvalid),
      .dn_ready       (rsp_tready),
      .bearing_deg    (bearing_deg),
      .correction_deg (correction_deg)
   );

   assign rsp_tdata = {{(RSP_W - 2*DEG_W){1'b0}}, correction_deg, bearing_deg};

endmodule

`default_nettype wire

// ===== rtl/bhc_prep.sv =====
// ----------------------------------------------------------------------------
// bhc_prep
// Input stage: coordinate differences, octant folding, exact handling of
// axis and diagonal directions, heading saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module bhc_prep import bhc_pkg::*; (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          up_valid,
   output logic                               up_ready,
   input  wire logic signed [COORD_WIDTH-1:0] robot_x,
   input  wire logic signed [COORD_WIDTH-1:0] robot_y,
   input  wire logic signed [COORD_WIDTH-1:0] target_x,
   input  wire logic signed [COORD_WIDTH-1:0] target_y,
   input  wire logic        [DEG_W-1:0]       heading_deg,
   output logic                               dn_valid,
   input  wire logic                          dn_ready,
   output cordic_type                         dn_data
);

   logic signed [COORD_WIDTH:0] dx;
   logic signed [COORD_WIDTH:0] dy;
   logic        [COORD_WIDTH:0] ax;
   logic        [COORD_WIDTH:0] ay;
   logic        [COORD_WIDTH:0] big;
   logic        [COORD_WIDTH:0] small_v;
   quad_type                    quad;
   side_type                    side;
   logic                        valid_ff;
   cordic_type                  data_ff;
   cordic_type                  data_in;

   // Exact differences and magnitudes
   always_comb begin
      dx   = $signed({robot_x[COORD_WIDTH-1], robot_x})
           - $signed({target_x[COORD_WIDTH-1], target_x});
      dy   = $signed({robot_y[COORD_WIDTH-1], robot_y})
           - $signed({target_y[COORD_WIDTH-1], target_y});
      ax   = dx[COORD_WIDTH] ? $unsigned(-dx) : $unsigned(dx);
      ay   = dy[COORD_WIDTH] ? $unsigned(-dy) : $unsigned(dy);
      quad = quad_type'({dx[COORD_WIDTH], dy[COORD_WIDTH]});
   end

   // Classify direction: raw bearing = base +/- first-octant angle
   always_comb begin
      side.special = 1'b1;
      side.sub     = 1'b0;
      side.base    = 9'd180;
      side.heading = (heading_deg > 9'd359) ? 9'd359 : heading_deg;
      big          = '0;
      small_v      = '0;
      if (ax == '0 && ay == '0) begin
         side.base = 9'd180;
      end else if (ay == '0) begin
         side.base = dx[COORD_WIDTH] ? 9'd360 : 9'd180;
      end else if (ax == '0) begin
         side.base = dy[COORD_WIDTH] ? 9'd90 : 9'd270;
      end else if (ax == ay) begin
         case (quad)
            QUAD_PP: side.base = 9'd225;
            QUAD_NP: side.base = 9'd315;
            QUAD_NN: side.base = 9'd45;
            QUAD_PN: side.base = 9'd135;
            default: side.base = 9'd180;
         endcase
      end else if (ay < ax) begin
         side.special = 1'b0;
         big          = ax;
         small_v      = ay;
         case (quad)
            QUAD_PP: begin side.base = 9'd180; side.sub = 1'b0; end
            QUAD_NP: begin side.base = 9'd360; side.sub = 1'b1; end
            QUAD_NN: begin side.base = 9'd0;   side.sub = 1'b0; end
            QUAD_PN: begin side.base = 9'd180; side.sub = 1'b1; end
            default: begin side.base = 9'd180; side.sub = 1'b0; end
         endcase
      end else begin
         side.special = 1'b0;
         big          = ay;
         small_v      = ax;
         case (quad)
            QUAD_PP: begin side.base = 9'd270; side.sub = 1'b1; end
            QUAD_NP: begin side.base = 9'd270; side.sub = 1'b0; end
            QUAD_NN: begin side.base = 9'd90;  side.sub = 1'b1; end
            QUAD_PN: begin side.base = 9'd90;  side.sub = 1'b0; end
            default: begin side.base = 9'd180; side.sub = 1'b0; end
         endcase
      end
   end

   // CORDIC start vector
   always_comb begin
      data_in.x    = $signed(XY_W'(big) << GUARD_BITS);
      data_in.y    = $signed(XY_W'(small_v) << GUARD_BITS);
      data_in.z    = '0;
      data_in.side = side;
   end

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

`default_nettype wire

// ===== rtl/bhc_cell.sv =====
// ----------------------------------------------------------------------------
// bhc_cell
// One CORDIC vectoring step: rotates (x, y) toward the x axis and
// accumulates the angle, then registers the result for the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module bhc_cell import bhc_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [STAGE_IDX_W-1:0] shift,   // tied to the cell index
   input  wire angle_type              atan,    // atan(2^-index) in degrees
   input  wire logic                   up_valid,
   output logic                        up_ready,
   input  wire cordic_type             up_data,
   output logic                        dn_valid,
   input  wire logic                   dn_ready,
   output cordic_type                  dn_data
);

   logic signed [XY_W-1:0] x_shr;
   logic signed [XY_W-1:0] y_shr;
   cordic_type             data_in;
   cordic_type             data_ff;
   logic                   valid_ff;

   // Micro-rotation, direction from the sign of y
   always_comb begin
      x_shr        = up_data.x >>> shift;
      y_shr        = up_data.y >>> shift;
      data_in.side = up_data.side;
      if (!up_data.y[XY_W-1]) begin
         data_in.x = up_data.x + y_shr;
         data_in.y = up_data.y - x_shr;
         data_in.z = up_data.z + atan;
      end else begin
         data_in.x = up_data.x - y_shr;
         data_in.y = up_data.y + x_shr;
         data_in.z = up_data.z - atan;
      end
   end

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

`default_nettype wire

// ===== rtl/bhc_post.sv =====
// ----------------------------------------------------------------------------
// bhc_post
// Output stages: clamp the octant angle, form the whole-degree raw bearing,
// then the mapped bearing and the wrapped heading correction.
// ----------------------------------------------------------------------------
`default_nettype none

module bhc_post import bhc_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    up_valid,
   output logic                         up_ready,
   input  wire cordic_type              up_data,
   output logic                         dn_valid,
   input  wire logic                    dn_ready,
   output logic        [DEG_W-1:0]      bearing_deg,
   output logic signed [DEG_W-1:0]      correction_deg
);

   localparam angle_type Z_MIN = angle_type'(1);
   localparam angle_type Z_MAX = angle_type'((64'd45 << ANGLE_FRAC) - 64'd1);

   angle_type                z_clamp;
   logic [RAW_W-1:0]         z_term;
   logic [RAW_W-1:0]         base_fix;
   logic [RAW_W-1:0]         raw;
   logic                     a_ready;
   logic                     b_ready;
   logic                     valid_a_ff;
   logic [DEG_W-1:0]         rawdeg_ff;
   logic [DEG_W-1:0]         heading_a_ff;
   logic signed [DEG_W:0]    diff;
   logic signed [DEG_W:0]    wrapped;
   logic                     valid_b_ff;
   logic [DEG_W-1:0]         bearing_ff;
   logic signed [DEG_W-1:0]  corr_ff;

   // Stage A: clamp and offset, floor by dropping the fraction
   always_comb begin
      if (up_data.z < Z_MIN) begin
         z_clamp = Z_MIN;
      end else if (up_data.z > Z_MAX) begin
         z_clamp = Z_MAX;
      end else begin
         z_clamp = up_data.z;
      end
      z_term   = up_data.side.special ? '0 : RAW_W'(z_clamp);
      base_fix = {up_data.side.base, {ANGLE_FRAC{1'b0}}};
      raw      = up_data.side.sub ? (base_fix - z_term) : (base_fix + z_term);
   end

   assign b_ready  = !valid_b_ff || dn_ready;
   assign a_ready  = !valid_a_ff || b_ready;
   assign up_ready = a_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else if (a_ready) begin
         valid_a_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && a_ready) begin
         rawdeg_ff    <= raw[RAW_W-1 -: DEG_W];
         heading_a_ff <= up_data.side.heading;
      end
   end

   // Stage B: correction wrapped once into -180..180
   always_comb begin
      diff = $signed({1'b0, rawdeg_ff}) - $signed({1'b0, heading_a_ff});
      if (diff > 10'sd180) begin
         wrapped = diff - 10'sd360;
      end else if (diff < -10'sd180) begin
         wrapped = diff + 10'sd360;
      end else begin
         wrapped = diff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else if (b_ready) begin
         valid_b_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (valid_a_ff && b_ready) begin
         bearing_ff <= (rawdeg_ff == 9'd360) ? 9'd0 : rawdeg_ff;
         corr_ff    <= wrapped[DEG_W-1:0];
      end
   end

   assign dn_valid       = valid_b_ff;
   assign bearing_deg    = bearing_ff;
   assign correction_deg = corr_ff;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Streams robot/target fixes with headings into the bearing and heading
// correction block. A bit-exact CORDIC predictor in the bench computes the
// expected bearing and turn for each accepted request. Both sides idle in
// random bursts. Each result is checked field by field against the oldest
// prediction.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import bhc_pkg::*;

   localparam int RANDOM_FIXES = 400;
   localparam int TAIL_ITEMS   = 40;                      // no idling this close to the end
   localparam int DRAIN_CYCLES = 2 * (CORDIC_STAGES + 3) + 10;
   localparam int CYCLE_LIMIT  = 100000;
   localparam int MAX_REPORTS  = 50;
   localparam int HALF_TURN    = 180;
   localparam int FULL_TURN    = 360;
   localparam int MAX_HEADING  = 359;
   localparam longint DEG_ONE  = longint'(1) << ANGLE_FRAC;
   localparam longint OCTANT   = longint'(45) << ANGLE_FRAC;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] robot_x;
      logic signed [COORD_WIDTH-1:0] robot_y;
      logic signed [COORD_WIDTH-1:0] target_x;
      logic signed [COORD_WIDTH-1:0] target_y;
      logic [DEG_W-1:0]              heading;
   } fix_request_type;

   typedef struct packed {
      logic [DEG_W-1:0] bearing;
      logic [DEG_W-1:0] correction;   // two's complement
   } steer_result_type;

   typedef struct packed {
      fix_request_type  src;
      steer_result_type want;
   } steer_entry_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   // robot_x, robot_y, target_x, target_y, heading_deg, zero fill
   logic [REQ_W-1:0]    req_tdata  = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   // bearing_deg, correction_deg, zero fill
   logic [RSP_W-1:0]    rsp_tdata;

   fix_request_type     fix_queue[$];
   steer_entry_type     steer_due[$];
   fix_request_type     on_bus;
   longint              atan_deg_q32 [CORDIC_STAGES];
   int                  req_gap         = 0;
   int                  rsp_gap         = 0;
   int                  fixes_sent      = 0;
   int                  results_checked = 0;
   int                  steer_errors    = 0;
   int unsigned         cycle_count     = 0;

   bearing_and_heading_correction DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      steer_errors++;
      if (steer_errors <= MAX_REPORTS) begin
         $display("[%0t] MISMATCH %s", $realtime, msg);
      end
   endtask

   task automatic queue_fix(input int rx, input int ry, input int tx, input int ty,
                            input int hd);
      fix_request_type r;
      r.robot_x  = rx[COORD_WIDTH-1:0];
      r.robot_y  = ry[COORD_WIDTH-1:0];
      r.target_x = tx[COORD_WIDTH-1:0];
      r.target_y = ty[COORD_WIDTH-1:0];
      r.heading  = hd[DEG_W-1:0];
      fix_queue.push_back(r);
   endtask

   // atan(short/long) in degrees with 32 fraction bits, 0 < short < long
   function automatic longint first_octant_angle(longint long_leg, longint short_leg);
      longint x, y, z, x_step, y_step;
      x = long_leg <<< GUARD_BITS;
      y = short_leg <<< GUARD_BITS;
      z = 0;
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         x_step = y >>> i;
         y_step = x >>> i;
         if (y >= 0) begin
            x = x + x_step;
            y = y - y_step;
            z = z + atan_deg_q32[i];
         end else begin
            x = x - x_step;
            y = y + y_step;
            z = z - atan_deg_q32[i];
         end
      end
      if (z < 1) z = 1;
      if (z > OCTANT - 1) z = OCTANT - 1;
      return z;
   endfunction

   // Expected bearing and turn for one fix
   function automatic steer_result_type predict_steer(fix_request_type r);
      longint           dx, dy, ax, ay, q, theta, raw, raw_deg, head, corr;
      steer_result_type s;
      dx = longint'(r.robot_x) - longint'(r.target_x);
      dy = longint'(r.robot_y) - longint'(r.target_y);
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      if (ax == 0 && ay == 0) begin
         theta = 0;
      end else begin
         // axis and diagonal directions are exact
         if (ay == 0) q = 0;
         else if (ax == 0) q = 90 * DEG_ONE;
         else if (ax == ay) q = 45 * DEG_ONE;
         else if (ay < ax) q = first_octant_angle(ax, ay);
         else q = 90 * DEG_ONE - first_octant_angle(ay, ax);
         if (dx >= 0 && dy >= 0) theta = q;
         else if (dx < 0 && dy >= 0) theta = HALF_TURN * DEG_ONE - q;
         else if (dx < 0) theta = q - HALF_TURN * DEG_ONE;
         else theta = -q;
      end
      raw = theta + HALF_TURN * DEG_ONE;
      if (raw < 0) raw = 0;
      raw_deg = raw >>> ANGLE_FRAC;
      if (raw_deg > FULL_TURN) raw_deg = FULL_TURN;
      head = longint'(r.heading);
      if (head > MAX_HEADING) head = MAX_HEADING;
      // unmapped 360 takes part in the turn
      corr = raw_deg - head;
      if (corr > HALF_TURN) corr = corr - FULL_TURN;
      else if (corr < -HALF_TURN) corr = corr + FULL_TURN;
      s.bearing    = (raw_deg == FULL_TURN) ? '0 : raw_deg[DEG_W-1:0];
      s.correction = corr[DEG_W-1:0];
      return s;
   endfunction

   // Request driver: holds a request until taken, idles in random bursts
   always @(posedge clock) begin
      steer_entry_type e;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            e.src  = on_bus;
            e.want = predict_steer(on_bus);
            steer_due.push_back(e);
            fixes_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap == 0 && fix_queue.size() > TAIL_ITEMS && (fixes_sent / 50) % 4 != 3
                && $urandom_range(0, 99) < 15) begin
               req_gap = $urandom_range(1, 14);
            end
            if (req_gap > 0 || fix_queue.size() == 0) begin
               if (req_gap > 0) req_gap--;
               req_tvalid <= 1'b0;
            end else begin
               on_bus = fix_queue.pop_front();
               req_tdata  <= REQ_W'({on_bus.heading, on_bus.target_y, on_bus.target_x,
                                     on_bus.robot_y, on_bus.robot_x});
               req_tvalid <= 1'b1;
            end
         end
      end
   end

   // Result monitor and receiver stalls
   always @(posedge clock) begin
      steer_entry_type e;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (steer_due.size() == 0) begin
               report_mismatch($sformatf("result %h with no request outstanding", rsp_tdata));
            end else begin
               e = steer_due.pop_front();
               results_checked++;
               if (rsp_tdata[DEG_W-1:0] !== e.want.bearing) begin
                  report_mismatch($sformatf(
                     "bearing got %0d want %0d (robot %0d,%0d target %0d,%0d)",
                     rsp_tdata[DEG_W-1:0], e.want.bearing, e.src.robot_x,
                     e.src.robot_y, e.src.target_x, e.src.target_y));
               end
               if (rsp_tdata[2*DEG_W-1:DEG_W] !== e.want.correction) begin
                  report_mismatch($sformatf(
                     "correction got %0d want %0d (robot %0d,%0d target %0d,%0d hdg %0d)",
                     $signed(rsp_tdata[2*DEG_W-1:DEG_W]), $signed(e.want.correction),
                     e.src.robot_x, e.src.robot_y, e.src.target_x, e.src.target_y,
                     e.src.heading));
               end
            end
         end
         if (rsp_gap == 0 && fix_queue.size() > TAIL_ITEMS && (cycle_count / 300) % 4 != 2
             && $urandom_range(0, 99) < 15) begin
            rsp_gap = $urandom_range(1, 14);
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, steer_due.size());
         $display("testbench: errors");
         $finish;
      end
   end

   // Arctangent table, stimulus and end of run
   initial begin : stimulus
      longint unsigned series, term, divisor;
      logic [127:0]    prod;
      int              k, n, mode, d, e, rx, ry, tx, ty, hd;
      int              corner_coords [7];

      corner_coords = '{-32768, -32767, -1, 0, 1, 32766, 32767};

      // atan(2^-i) in degrees from the radian series, scaled by 180/pi
      atan_deg_q32[0] = OCTANT;
      for (int i = 1; i < CORDIC_STAGES; i++) begin
         series = 0;
         k      = 0;
         while (i * (2 * k + 1) < 62) begin
            n       = i * (2 * k + 1);
            divisor = 2 * k + 1;
            term    = (64'd1 << (62 - n)) / divisor;
            if (k % 2 == 1) series = series - term;
            else series = series + term;
            k++;
         end
         prod            = {64'd0, series} * {64'd0, RAD_TO_DEG_Q32};
         atan_deg_q32[i] = longint'(prod[125:62]);
      end

      // directed: equal points, axes, diagonals, coordinate extremes,
      // heading saturation and both wrap directions
      queue_fix(0, 0, 0, 0, 0);
      queue_fix(100, -50, 100, -50, 359);
      queue_fix(-5, 0, 0, 0, 0);                       // raw 360
      queue_fix(-5, 7, 0, 7, 359);
      queue_fix(-32768, 0, 32767, 0, 180);
      queue_fix(32767, 0, -32768, 0, 0);
      queue_fix(0, 32767, 0, -32768, 90);
      queue_fix(0, -32768, 0, 32767, 270);
      queue_fix(32767, 32767, -32768, -32768, 45);
      queue_fix(-32768, 32767, 32767, -32768, 315);
      queue_fix(-20, -20, 0, 0, 0);
      queue_fix(20, -20, 0, 0, 359);
      queue_fix(32767, -1, -32768, 0, 0);
      queue_fix(-32768, 1, 32767, 0, 0);
      queue_fix(-32768, -1, 32767, 0, 0);
      queue_fix(-32768, -1, 32767, 0, 359);           // wraps up
      queue_fix(1, -32768, 0, 32767, 360);             // heading saturates
      queue_fix(1000, 999, 0, 0, 511);
      queue_fix(999, 1000, 0, 0, 256);
      queue_fix(3, 1, 0, 0, 0);
      queue_fix(1, 3, 0, 0, 100);
      queue_fix(-32767, 32767, 32767, -32768, 1);

      // random fixes, biased toward near points, axes and diagonals
      for (int j = 0; j < RANDOM_FIXES; j++) begin
         rx   = $urandom_range(0, 65535) - 32768;
         ry   = $urandom_range(0, 65535) - 32768;
         tx   = $urandom_range(0, 65535) - 32768;
         ty   = $urandom_range(0, 65535) - 32768;
         mode = $urandom_range(0, 9);
         case (mode)
            4, 5: begin
               tx = rx + $urandom_range(0, 600) - 300;
               ty = ry + $urandom_range(0, 600) - 300;
            end
            6: begin
               if ($urandom_range(0, 1) == 1) tx = rx;
               else ty = ry;
            end
            7, 8: begin
               rx = $urandom_range(0, 32767) - 16384;
               ry = $urandom_range(0, 32767) - 16384;
               d  = $urandom_range(1, 16383);
               // exact diagonal, or one off it
               e  = (mode == 7) ? d : d + ($urandom_range(0, 1) == 1 ? 1 : -1);
               tx = rx + (($urandom_range(0, 1) == 1) ? d : -d);
               ty = ry + (($urandom_range(0, 1) == 1) ? e : -e);
            end
            9: begin
               rx = corner_coords[$urandom_range(0, 6)];
               ry = corner_coords[$urandom_range(0, 6)];
               tx = corner_coords[$urandom_range(0, 6)];
               ty = corner_coords[$urandom_range(0, 6)];
            end
            default: ;
         endcase
         hd = ($urandom_range(0, 19) == 0) ? $urandom_range(360, 511) : $urandom_range(0, 359);
         queue_fix(rx, ry, tx, ty, hd);
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // drain: all requests taken and all results back
      do @(negedge clock); while (fix_queue.size() > 0 || req_tvalid || steer_due.size() > 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (steer_due.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", steer_due.size()));
      end

      $display("%0d fixes sent (edge, axis, diagonal and random geometry, saturated headings),",
               fixes_sent);
      $display("%0d bearing/correction results compared, %0d mismatches",
               results_checked, steer_errors);
      if (steer_errors == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
